FILE: rtl/gas_sensor_load_scan_sequencer_defines.svh
// assertion macros for the load scan sequencer
`ifndef GAS_SENSOR_LOAD_SCAN_SEQUENCER_DEFINES_SVH
`define GAS_SENSOR_LOAD_SCAN_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define GSLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSLS_ASSERT_SAME(lbl, ante, cons, msg)
`define GSLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/gsls_pkg.sv
package gsls_pkg;

    localparam int HISTORY_COLUMNS = 320;
    localparam int CHANNELS        = 7;

    localparam int COL_W   = 9;
    localparam int PHASE_W = 4;
    localparam int CODES_W = 3 * CHANNELS;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * CHANNELS);
    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(HISTORY_COLUMNS - 1);

    localparam logic [CODES_W-1:0] RESET_CODES   = CODES_W'(2053768);
    localparam logic [7:0]         RESET_CEILING = 8'd239;
    localparam logic [7:0]         TRACE_OFFSET  = 8'd239;
    localparam logic [2:0]         TRACE_ROW     = 3'd7;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESISTOR_CODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CEILING  = 2'd1;

    typedef enum logic [1:0] {
        STEP_SELECT    = 2'd0,
        STEP_SAMPLE    = 2'd1,
        STEP_FRAME_END = 2'd2
    } t_step_kind;

    typedef struct packed {
        logic signed [15:0] adc_sample;
        logic               adc_error;
    } t_in_item;

    typedef struct packed {
        t_step_kind       step_kind;
        logic [2:0]       resistor_select;
        logic [2:0]       channel;
        logic [7:0]       trace_value;
        logic [2:0]       history_row;
        logic [COL_W-1:0] history_column;
        logic [7:0]       max_rise;
        logic             sample_failed;
        logic             indicator;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_write;

endpackage

FILE: rtl/gsls_in_if.sv
interface gsls_in_if;
    logic               valid;
    logic               ready;
    gsls_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gsls_out_if.sv
interface gsls_out_if;
    logic                valid;
    logic                ready;
    gsls_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gsls_cfg_if.sv
interface gsls_cfg_if;
    logic                 valid;
    logic                 ready;
    gsls_pkg::t_cfg_write data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gas_sensor_load_scan_sequencer.sv
// channel  | dir | payload                                   | transaction when
// i_in     | in  | adc_sample, adc_error                     | valid && ready
// i_cfg    | in  | index (0 resistor codes, 1 level ceiling) | valid && ready
// o_res    | out | step kind, select, channel, history write | valid && ready
//
// one tick per cycle while the sink keeps taking results; each tick yields its result in the next cycle
// the result register is the only stage, input ready is low only while it holds
// a result that the sink is not taking
// reset is synchronous and restores phase, column, rise, indicator, per-channel
// held samples and levels, and both configuration registers
// configuration writes are always taken
`include "gas_sensor_load_scan_sequencer_defines.svh"

module gas_sensor_load_scan_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsls_in_if.sink    i_in,
    gsls_cfg_if.sink   i_cfg,
    gsls_out_if.source o_res
);

    logic [gsls_pkg::CODES_W-1:0] r_codes;
    logic [7:0]                   r_ceiling;

    logic [gsls_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [gsls_pkg::COL_W-1:0]   r_column, n_column;
    logic [7:0]                   r_frame_rise, n_frame_rise;
    logic                         r_indicator, n_indicator;
    logic [7:0]                   r_prev_level [gsls_pkg::CHANNELS];
    logic [15:0]                  r_held [gsls_pkg::CHANNELS];

    gsls_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;

    logic       in_accept;
    logic       wr_sample;
    logic [2:0] ch;
    logic [15:0] sample;
    logic [7:0]  level_raw;
    logic [7:0]  level;
    logic [7:0]  prev;
    logic [7:0]  rise;
    logic [8:0]  trace_sum;

    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_phase      = r_phase;
        n_column     = r_column;
        n_frame_rise = r_frame_rise;
        n_indicator  = r_indicator;
        wr_sample    = 1'b0;

        ch        = r_phase[3:1];
        sample    = i_in.data.adc_error ? r_held[ch] : 16'(i_in.data.adc_sample);
        level_raw = {~sample[15], sample[14:8]};
        level     = (level_raw > r_ceiling) ? r_ceiling : level_raw;
        prev      = r_prev_level[ch];
        rise      = level - prev;
        trace_sum = {1'b0, r_frame_rise} + {1'b0, gsls_pkg::TRACE_OFFSET};

        n_out.step_kind       = gsls_pkg::STEP_SELECT;
        n_out.resistor_select = 3'd0;
        n_out.channel         = 3'd0;
        n_out.trace_value     = 8'd0;
        n_out.history_row     = 3'd0;
        n_out.history_column  = r_column;
        n_out.max_rise        = r_frame_rise;
        n_out.sample_failed   = 1'b0;
        n_out.indicator       = r_indicator;

        if (r_phase >= gsls_pkg::PHASE_LAST) begin
            n_out.step_kind   = gsls_pkg::STEP_FRAME_END;
            n_out.trace_value = trace_sum[8:1];
            n_out.history_row = gsls_pkg::TRACE_ROW;
            n_column          = (r_column == gsls_pkg::COL_LAST) ? '0 : r_column + 1'b1;
            n_indicator       = !r_indicator;
            n_frame_rise      = 8'd0;
            n_phase           = '0;
        end else begin
            n_out.channel         = ch;
            n_out.resistor_select = r_codes[5'(ch) * 5'd3 +: 3];
            n_phase               = r_phase + 1'b1;
            if (r_phase[0]) begin
                wr_sample           = 1'b1;
                n_out.step_kind     = gsls_pkg::STEP_SAMPLE;
                n_out.sample_failed = i_in.data.adc_error;
                n_out.trace_value   = level;
                n_out.history_row   = ch;
                if (level > prev && rise > r_frame_rise) begin
                    n_frame_rise = rise;
                end
                n_out.max_rise = n_frame_rise;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes      <= gsls_pkg::RESET_CODES;
            r_ceiling    <= gsls_pkg::RESET_CEILING;
            r_phase      <= '0;
            r_column     <= '0;
            r_frame_rise <= 8'd0;
            r_indicator  <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < gsls_pkg::CHANNELS; i++) begin
                r_prev_level[i] <= 8'd0;
                r_held[i]       <= 16'd0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    gsls_pkg::CFG_RESISTOR_CODES: begin
                        r_codes <= i_cfg.data.value[gsls_pkg::CODES_W-1:0];
                    end
                    gsls_pkg::CFG_LEVEL_CEILING: begin
                        r_ceiling <= i_cfg.data.value[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_phase      <= n_phase;
                r_column     <= n_column;
                r_frame_rise <= n_frame_rise;
                r_indicator  <= n_indicator;
                if (wr_sample) begin
                    r_prev_level[ch] <= level;
                    if (!i_in.data.adc_error) begin
                        r_held[ch] <= 16'(i_in.data.adc_sample);
                    end
                end
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    `GSLS_ASSERT_SAME(a_phase_range, 1'b1, r_phase <= gsls_pkg::PHASE_LAST, "phase out of range")
    `GSLS_ASSERT_NEXT(a_frame_restart, in_accept && r_phase == gsls_pkg::PHASE_LAST, r_phase == '0 && r_frame_rise == 8'd0 && r_indicator != $past(r_indicator), "frame end did not restart")
    `GSLS_ASSERT_NEXT(a_phase_step, in_accept && r_phase < gsls_pkg::PHASE_LAST, r_phase == $past(r_phase) + 1'b1 && r_column == $past(r_column), "phase did not advance")
    `GSLS_ASSERT_SAME(a_select_quiet, r_out_valid && r_out.step_kind == gsls_pkg::STEP_SELECT, r_out.trace_value == 8'd0 && r_out.history_row == 3'd0 && !r_out.sample_failed, "select step carries history data")

endmodule

FILE: tb/tb_gas_sensor_load_scan_sequencer.sv
`timescale 1ns / 100ps

module tb_gas_sensor_load_scan_sequencer;

    localparam int DIR_ROWS       = 20;
    localparam int SETTING_RUNS   = 6;
    localparam int RUN_ITEMS      = 140;
    localparam int LONG_HOLD      = 400;
    localparam int FRAME_STEPS    = 2 * gsls_pkg::CHANNELS + 1;
    localparam int STREAM_FRAMES  = 10;
    localparam int TIMEOUT_CYCLES = 400_000;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_MOSTLY
    } t_rx_mode;

    typedef struct packed {
        logic signed [15:0]  adc_word;
        logic                err;
        logic                typed;
        gsls_pkg::t_out_item want;
    } t_dir_row;

    localparam gsls_pkg::t_out_item NO_RESULT = '0;

    logic i_clk;
    logic i_rst_n;

    gsls_in_if  in_if ();
    gsls_cfg_if cfg_if ();
    gsls_out_if res_if ();

    gas_sensor_load_scan_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // directed ticks right after reset, reset settings in force
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{16'sh0000, 1'b0, 1'b1,
          '{gsls_pkg::STEP_SELECT, 3'd0, 3'd0, 8'd0, 3'd0, 9'd0, 8'd0, 1'b0, 1'b0}},
        '{16'sh7fff, 1'b0, 1'b1,
          '{gsls_pkg::STEP_SAMPLE, 3'd0, 3'd0, 8'd239, 3'd0, 9'd0, 8'd239, 1'b0, 1'b0}},
        '{16'sh1234, 1'b0, 1'b1,
          '{gsls_pkg::STEP_SELECT, 3'd1, 3'd1, 8'd0, 3'd0, 9'd0, 8'd239, 1'b0, 1'b0}},
        '{16'sh8000, 1'b0, 1'b1,
          '{gsls_pkg::STEP_SAMPLE, 3'd1, 3'd1, 8'd0, 3'd1, 9'd0, 8'd239, 1'b0, 1'b0}},
        '{16'shffff, 1'b1, 1'b0, NO_RESULT},
        '{16'sh7fff, 1'b1, 1'b1,
          '{gsls_pkg::STEP_SAMPLE, 3'd2, 3'd2, 8'd128, 3'd2, 9'd0, 8'd239, 1'b1, 1'b0}},
        '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
        '{16'sh00ff, 1'b0, 1'b0, NO_RESULT},
        '{16'sh5555, 1'b1, 1'b0, NO_RESULT},
        '{16'shffff, 1'b0, 1'b0, NO_RESULT},
        '{16'shaaaa, 1'b0, 1'b0, NO_RESULT},
        '{16'sh5a5a, 1'b0, 1'b0, NO_RESULT},
        '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
        '{16'sh7f00, 1'b1, 1'b0, NO_RESULT},
        '{16'sh8000, 1'b1, 1'b1,
          '{gsls_pkg::STEP_FRAME_END, 3'd0, 3'd0, 8'd239, 3'd7, 9'd0, 8'd239, 1'b0, 1'b0}},
        '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
        '{16'sh0001, 1'b1, 1'b0, NO_RESULT},
        '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
        '{16'sh4000, 1'b0, 1'b0, NO_RESULT},
        '{16'sh7fff, 1'b1, 1'b0, NO_RESULT}
    };

    // scan model state and settings
    logic [gsls_pkg::PHASE_W-1:0] phase_q = '0;
    logic [gsls_pkg::COL_W-1:0]   col_q   = '0;
    logic [7:0]                   rise_q  = '0;
    logic                         ind_q   = 1'b0;
    logic [7:0]                   prev_q [gsls_pkg::CHANNELS] = '{default: 8'h00};
    logic [15:0]                  held_q [gsls_pkg::CHANNELS] = '{default: 16'h0000};
    logic [gsls_pkg::CODES_W-1:0] codes_q = gsls_pkg::RESET_CODES;
    logic [7:0]                   ceil_q  = gsls_pkg::RESET_CEILING;

    gsls_pkg::t_out_item scan_results_due [$];
    gsls_pkg::t_out_item want_res;

    int       error_count  = 0;
    int       ticks_sent   = 0;
    int       results_seen = 0;
    int       frames_done  = 0;
    int       col_wraps    = 0;
    bit       long_hold_req = 1'b0;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_span = 0;
    int       rx_tick = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic gsls_pkg::t_out_item next_scan_result(input gsls_pkg::t_in_item tick);
        gsls_pkg::t_out_item r;
        logic [2:0]          ch;
        logic [7:0]          lvl;
        r = '0;
        r.history_column = col_q;
        r.indicator = ind_q;
        if (phase_q >= gsls_pkg::PHASE_LAST) begin
            r.step_kind = gsls_pkg::STEP_FRAME_END;
            r.trace_value = 8'((int'(rise_q) + int'(gsls_pkg::TRACE_OFFSET)) >> 1);
            r.history_row = gsls_pkg::TRACE_ROW;
            r.max_rise = rise_q;
            if (col_q == gsls_pkg::COL_LAST) begin
                col_q = '0;
                col_wraps++;
            end else begin
                col_q = col_q + 9'd1;
            end
            ind_q = ~ind_q;
            rise_q = '0;
            phase_q = '0;
            frames_done++;
        end else begin
            ch = phase_q[3:1];
            r.channel = ch;
            r.resistor_select = codes_q[3*ch +: 3];
            if (phase_q[0]) begin
                r.step_kind = gsls_pkg::STEP_SAMPLE;
                r.sample_failed = tick.adc_error;
                if (!tick.adc_error) begin
                    held_q[ch] = tick.adc_sample;
                end
                lvl = {~held_q[ch][15], held_q[ch][14:8]};
                if (lvl > ceil_q) begin
                    lvl = ceil_q;
                end
                if (lvl > prev_q[ch] && (lvl - prev_q[ch]) > rise_q) begin
                    rise_q = lvl - prev_q[ch];
                end
                prev_q[ch] = lvl;
                r.trace_value = lvl;
                r.history_row = ch;
            end else begin
                r.step_kind = gsls_pkg::STEP_SELECT;
            end
            r.max_rise = rise_q;
            phase_q = phase_q + 4'd1;
        end
        return r;
    endfunction

    task automatic send_tick(input logic signed [15:0] adc_word, input logic err,
                             input logic typed, input gsls_pkg::t_out_item typed_res);
        gsls_pkg::t_in_item  tick;
        gsls_pkg::t_out_item predicted;
        tick = '{adc_sample: adc_word, adc_error: err};
        in_if.valid <= 1'b1;
        in_if.data <= tick;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        ticks_sent++;
        predicted = next_scan_result(tick);
        scan_results_due.push_back(typed ? typed_res : predicted);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [gsls_pkg::CODES_W-1:0] codes,
                                  input logic [7:0] ceiling);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: gsls_pkg::CFG_RESISTOR_CODES,
                         value: {11'($urandom), codes}};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        codes_q = codes;
        cfg_if.data <= '{index: gsls_pkg::CFG_LEVEL_CEILING,
                         value: {24'($urandom), ceiling}};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        ceil_q = ceiling;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit with_gaps);
        int                 burst_left;
        int                 k;
        logic signed [15:0] adc_word;
        logic               err;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                adc_word = 16'sh7fff;
            end else if (k == 1) begin
                adc_word = 16'sh8000;
            end else begin
                adc_word = 16'($urandom);
            end
            err = ($urandom_range(0, 7) == 0);
            send_tick(adc_word, err, 1'b0, NO_RESULT);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (with_gaps) begin
                    idle_for($urandom_range(1, 6));
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (scan_results_due.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, res_if.data);
                error_count++;
            end else begin
                want_res = scan_results_due.pop_front();
                check_field("step_kind", int'(want_res.step_kind),
                            int'(res_if.data.step_kind));
                check_field("resistor_select", int'(want_res.resistor_select),
                            int'(res_if.data.resistor_select));
                check_field("channel", int'(want_res.channel), int'(res_if.data.channel));
                check_field("trace_value", int'(want_res.trace_value),
                            int'(res_if.data.trace_value));
                check_field("history_row", int'(want_res.history_row),
                            int'(res_if.data.history_row));
                check_field("history_column", int'(want_res.history_column),
                            int'(res_if.data.history_column));
                check_field("max_rise", int'(want_res.max_rise), int'(res_if.data.max_rise));
                check_field("sample_failed", int'(want_res.sample_failed),
                            int'(res_if.data.sample_failed));
                check_field("indicator", int'(want_res.indicator),
                            int'(res_if.data.indicator));
            end
        end
    end

    // result sink with its own stall pattern
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (rx_span == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_span = $urandom_range(4, 64);
                end
                rx_span--;
                rx_tick++;
                case (rx_mode)
                    RX_ALWAYS: res_if.ready <= 1'b1;
                    RX_COIN: res_if.ready <= ($urandom_range(0, 1) == 0);
                    RX_EVERY_FOURTH: res_if.ready <= (rx_tick % 4 == 0);
                    default: res_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            send_tick(dir_tbl[k].adc_word, dir_tbl[k].err, dir_tbl[k].typed, dir_tbl[k].want);
            if ($urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 3));
            end
        end
        drain_results();

        for (int sx = 0; sx < SETTING_RUNS; sx++) begin
            case (sx)
                0: ;
                1: write_settings({gsls_pkg::CODES_W{1'b1}}, 8'hff);
                2: begin
                    write_settings('0, 8'h00);
                    long_hold_req = 1'b1;
                end
                4: write_settings(gsls_pkg::CODES_W'($urandom), gsls_pkg::RESET_CEILING);
                default: write_settings(gsls_pkg::CODES_W'($urandom), 8'($urandom));
            endcase
            run_random(RUN_ITEMS, 1'b1);
            drain_results();
        end

        // back-to-back stream of whole frames' worth of ticks with the widest ceiling
        write_settings(gsls_pkg::CODES_W'($urandom), 8'hff);
        run_random(STREAM_FRAMES * FRAME_STEPS, 1'b0);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d ticks, %0d checked results, %0d frames, %0d column wraps",
                 ticks_sent, results_seen, frames_done, col_wraps);
        $display("settings spanned reset, all-ones and all-zero codes, ceilings 0/239/255");
        if (error_count == 0 && scan_results_due.size() == 0) begin
            $display("tb_gas_sensor_load_scan_sequencer OK");
        end else begin
            $display("tb_gas_sensor_load_scan_sequencer NOT OK");
        end
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("timeout with %0d results still due", scan_results_due.size());
        $display("tb_gas_sensor_load_scan_sequencer NOT OK");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/gsls_pkg.sv
rtl/gsls_in_if.sv
rtl/gsls_out_if.sv
rtl/gsls_cfg_if.sv
rtl/gas_sensor_load_scan_sequencer.sv
tb/tb_gas_sensor_load_scan_sequencer.sv
